### rtl/hkct_pkg.sv
`default_nettype none
package hkct_pkg;

  localparam int MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    ST_CHORD  = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_REPEAT = 3'd2,
    ST_DUP    = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] scan_code;
    logic [7:0] event_flags;
  } key_event_t;

  typedef struct packed {
    logic [7:0] held_code;
    logic [3:0] slot;
    logic       last_of_run;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] key;
  } cell_t;

endpackage
`default_nettype wire

### rtl/hkct_cell.sv
`default_nettype none
module hkct_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hkct_pkg::cell_op_t op,
  input  wire logic [7:0]        code,
  input  wire hkct_pkg::cell_t   left,
  input  wire logic              left_lt,
  input  wire hkct_pkg::cell_t   right,
  output hkct_pkg::cell_t        cur,
  output logic                   lt,
  output logic                   eq
);

  hkct_pkg::cell_t cur_next;

  assign lt = cur.vld && (cur.key < code);
  assign eq = cur.vld && (cur.key == code);

  always_comb begin
    cur_next = cur;
    unique case (op)
      hkct_pkg::OP_HOLD: begin
        cur_next = cur;
      end
      hkct_pkg::OP_INSERT: begin
        // keep smaller codes, place the new code at the boundary, shift the rest up
        if (!lt) begin
          if (left_lt) begin
            cur_next.vld = 1'b1;
            cur_next.key = code;
          end else begin
            cur_next = left;
          end
        end
      end
      hkct_pkg::OP_DELETE: begin
        // the matching cell and all above it pull from the right
        if (cur.vld && (cur.key >= code)) begin
          cur_next = right;
        end
      end
      hkct_pkg::OP_ROTATE: begin
        cur_next = right;
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur.vld <= cur_next.vld;
    end
    cur.key <= cur_next.key;
  end

endmodule
`default_nettype wire

### rtl/held_key_chord_tracker_top.sv
`default_nettype none
// Repeat, refused press and empty-chord items: one result on the cycle after accept,
// busy stays low, so an item can be taken every cycle.
// Chord items: the cell row rotates once around in S_EMIT, emitting the held codes
// from cell 0, at most MAX_RESULTS of them; busy stays high for the whole turn,
// so no new item is taken until the turn is done.
// Synchronous reset empties the held set and forgets the previous event.
module held_key_chord_tracker_top #(
  parameter int MAX_HELD = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire hkct_pkg::key_event_t key_event,
  output hkct_pkg::result_t         result,
  output logic                      result_strobe
);

  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int IW = $clog2(MAX_HELD);
  localparam int NR = (MAX_HELD < hkct_pkg::MAX_RESULTS) ? MAX_HELD : hkct_pkg::MAX_RESULTS;

  hkct_pkg::state_t  state, state_next;
  logic [IW-1:0]     idx, idx_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     n_out;
  logic [7:0]        prev_key, prev_scan, prev_flags;
  logic              prev_valid;
  logic              prev_upd;
  hkct_pkg::result_t result_next;
  logic              result_strobe_next;
  hkct_pkg::cell_op_t op;

  hkct_pkg::cell_t   cells [MAX_HELD];
  logic [MAX_HELD-1:0] lt_vec, eq_vec, vld_vec;
  hkct_pkg::cell_t   last_right;

  logic accept, is_repeat, is_release, dup, found, full;

  genvar g;
  generate
    for (g = 0; g < MAX_HELD; g++) begin : g_cell
      hkct_pkg::cell_t left_in, right_in;
      logic            left_lt_in;
      if (g == 0) begin : g_first
        assign left_in    = '0;
        assign left_lt_in = 1'b1;
      end else begin : g_mid
        assign left_in    = cells[g-1];
        assign left_lt_in = lt_vec[g-1];
      end
      if (g == MAX_HELD - 1) begin : g_last
        assign right_in = last_right;
      end else begin : g_inner
        assign right_in = cells[g+1];
      end
      hkct_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .op      (op),
        .code    (key_event.key_code),
        .left    (left_in),
        .left_lt (left_lt_in),
        .right   (right_in),
        .cur     (cells[g]),
        .lt      (lt_vec[g]),
        .eq      (eq_vec[g])
      );
      assign vld_vec[g] = cells[g].vld;
    end
  endgenerate

  // close the ring only while emitting
  assign last_right = (op == hkct_pkg::OP_ROTATE) ? cells[0] : '0;

  assign busy       = (state == hkct_pkg::S_EMIT);
  assign accept     = start && !busy;
  assign is_repeat  = prev_valid && (prev_key == key_event.key_code) &&
                      (prev_scan == key_event.scan_code) &&
                      (prev_flags == key_event.event_flags);
  assign is_release = key_event.event_flags[7];
  assign found      = |eq_vec;
  assign dup        = found;
  assign full       = (count == CW'(MAX_HELD));
  assign n_out      = (count > CW'(NR)) ? CW'(NR) : count;

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    count_next         = count;
    op                 = hkct_pkg::OP_HOLD;
    prev_upd           = 1'b0;
    result_next        = '0;
    result_strobe_next = 1'b0;
    unique case (state)
      hkct_pkg::S_IDLE: begin
        if (accept) begin
          result_next.last_of_run = 1'b1;
          if (is_repeat) begin
            result_next.status = hkct_pkg::ST_REPEAT;
            result_strobe_next = 1'b1;
          end else begin
            prev_upd = 1'b1;
            if (!is_release && dup) begin
              result_next.status = hkct_pkg::ST_DUP;
              result_strobe_next = 1'b1;
            end else if (!is_release && full) begin
              result_next.status = hkct_pkg::ST_FULL;
              result_strobe_next = 1'b1;
            end else begin
              if (is_release) begin
                if (found) begin
                  op         = hkct_pkg::OP_DELETE;
                  count_next = count - CW'(1);
                end
              end else begin
                op         = hkct_pkg::OP_INSERT;
                count_next = count + CW'(1);
              end
              if (count_next == '0) begin
                result_next.status = hkct_pkg::ST_EMPTY;
                result_strobe_next = 1'b1;
              end else begin
                state_next = hkct_pkg::S_EMIT;
                idx_next   = '0;
              end
            end
          end
        end
      end
      hkct_pkg::S_EMIT: begin
        op = hkct_pkg::OP_ROTATE;
        if (CW'(idx) < n_out) begin
          result_next.held_code   = cells[0].key;
          result_next.slot        = 4'(idx);
          result_next.last_of_run = (CW'(idx) == n_out - CW'(1));
          result_next.status      = hkct_pkg::ST_CHORD;
          result_strobe_next      = 1'b1;
        end
        // one full turn brings the row back into sorted position
        if (idx == IW'(MAX_HELD - 1)) begin
          state_next = hkct_pkg::S_IDLE;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      default: begin
        state_next = hkct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hkct_pkg::S_IDLE;
      idx           <= '0;
      count         <= '0;
      prev_valid    <= 1'b0;
      prev_key      <= '0;
      prev_scan     <= '0;
      prev_flags    <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      idx           <= idx_next;
      count         <= count_next;
      result_strobe <= result_strobe_next;
      if (prev_upd) begin
        prev_valid <= 1'b1;
        prev_key   <= key_event.key_code;
        prev_scan  <= key_event.scan_code;
        prev_flags <= key_event.event_flags;
      end
    end
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_HELD))
    else $error("held count above capacity");

  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(count))
    else $error("valid cells disagree with held count");

  a_accept_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_strobe || busy))
    else $error("accepted item produced no result");
`endif

endmodule
`default_nettype wire

### test/tb_held_key_chord_tracker_top.sv
`timescale 1ns / 1ps
module tb_held_key_chord_tracker_top;

  localparam int HELD_DEPTH     = 16;
  localparam int RANDOM_EVENTS  = 245;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    hkct_pkg::key_event_t ev;
    bit                   typed;
    hkct_pkg::result_t    want;
  } key_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  hkct_pkg::key_event_t key_event = '0;
  hkct_pkg::result_t    result;
  logic                 result_strobe;

  // predictor state
  logic [7:0]           held_set [HELD_DEPTH];
  int                   held_num;
  hkct_pkg::key_event_t last_ev;
  bit                   last_ok;

  hkct_pkg::result_t    chord_expect [$];
  key_row_t             key_rows [$];
  hkct_pkg::result_t    oldest;
  int                   errors;
  int                   events_sent;
  int                   results_seen;
  int                   status_seen [8];
  int                   idle_cycles;
  bit                   burst;

  held_key_chord_tracker_top #(
    .MAX_HELD(HELD_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .key_event(key_event),
    .result(result),
    .result_strobe(result_strobe)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic hkct_pkg::result_t mk_result(logic [7:0] code, int idx, bit last,
                                                  hkct_pkg::status_t st);
    hkct_pkg::result_t r;
    r.held_code   = code;
    r.slot        = idx[3:0];
    r.last_of_run = last;
    r.status      = st;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] k, logic [7:0] s, logic [7:0] f, bit typed,
                                  hkct_pkg::result_t want);
    key_row_t row;
    row.ev.key_code    = k;
    row.ev.scan_code   = s;
    row.ev.event_flags = f;
    row.typed          = typed;
    row.want           = want;
    key_rows.push_back(row);
  endfunction

  // Update the held set for one accepted event and queue the results expected from it.
  function automatic void predict_chord(hkct_pkg::key_event_t ev, bit typed,
                                        hkct_pkg::result_t want);
    int pos;
    int n;
    bit found;
    hkct_pkg::status_t st;
    st = hkct_pkg::ST_CHORD;
    if (last_ok && ev == last_ev) begin
      st = hkct_pkg::ST_REPEAT;
    end else begin
      last_ev = ev;
      last_ok = 1'b1;
      if (ev.event_flags[7]) begin
        found = 1'b0;
        for (int i = 0; i < held_num; i++) begin
          if (!found && held_set[i] == ev.key_code) found = 1'b1;
          if (found && i + 1 < held_num) held_set[i] = held_set[i + 1];
        end
        if (found) begin
          held_num--;
          held_set[held_num] = '0;
        end
      end else begin
        pos = held_num;
        for (int i = 0; i < held_num; i++) begin
          if (st == hkct_pkg::ST_CHORD && pos == held_num) begin
            if (held_set[i] == ev.key_code) st = hkct_pkg::ST_DUP;
            else if (held_set[i] > ev.key_code) pos = i;
          end
        end
        if (st == hkct_pkg::ST_CHORD && held_num >= HELD_DEPTH) st = hkct_pkg::ST_FULL;
        if (st == hkct_pkg::ST_CHORD) begin
          for (int i = held_num; i > pos; i--) held_set[i] = held_set[i - 1];
          held_set[pos] = ev.key_code;
          held_num++;
        end
      end
      if (st == hkct_pkg::ST_CHORD && held_num == 0) st = hkct_pkg::ST_EMPTY;
    end
    if (typed) begin
      chord_expect.push_back(want);
    end else if (st != hkct_pkg::ST_CHORD) begin
      chord_expect.push_back(mk_result('0, 0, 1'b1, st));
    end else begin
      n = (held_num > hkct_pkg::MAX_RESULTS) ? hkct_pkg::MAX_RESULTS : held_num;
      for (int i = 0; i < n; i++)
        chord_expect.push_back(mk_result(held_set[i], i, i == n - 1, hkct_pkg::ST_CHORD));
    end
  endfunction

  // Hold off for a random gap unless in burst mode, then present the item until it is taken.
  task automatic issue(hkct_pkg::key_event_t ev, bit typed, hkct_pkg::result_t want);
    int gap;
    int r;
    gap = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 40);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    key_event <= ev;
    do @(posedge clk); while (busy);
    events_sent++;
    predict_chord(ev, typed, want);
  endtask

  task automatic drain_chords();
    start <= 1'b0;
    @(posedge clk);
    while (chord_expect.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, hkct_pkg::result_t want,
                               hkct_pkg::result_t got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $write("%0t: %s: expected code %02h slot %0d last %0b status %0d, ",
             $realtime, what, want.held_code, want.slot, want.last_of_run, want.status);
      $display("got code %02h slot %0d last %0b status %0d",
               got.held_code, got.slot, got.last_of_run, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      results_seen++;
      status_seen[result.status]++;
      if (chord_expect.size() == 0) begin
        note_mismatch("result with nothing expected", '0, result);
      end else begin
        oldest = chord_expect.pop_front();
        if (result.held_code !== oldest.held_code || result.slot !== oldest.slot ||
            result.last_of_run !== oldest.last_of_run || result.status !== oldest.status)
          note_mismatch("chord mismatch", oldest, result);
      end
    end
  end

  // Count cycles where neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed", $realtime,
               WATCHDOG_LIMIT, chord_expect.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    hkct_pkg::key_event_t ev;
    hkct_pkg::key_event_t last_sent;
    logic [7:0] fill_keys [15];
    int press_pct;
    int r;

    errors       = 0;
    events_sent  = 0;
    results_seen = 0;
    burst        = 1'b0;
    held_num     = 0;
    last_ok      = 1'b0;
    last_ev      = '0;
    for (int i = 0; i < HELD_DEPTH; i++) held_set[i] = '0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;

    // first event matches the reset value of the last event, but is no repeat
    add_row(8'h00, 8'h00, 8'h00, 1'b1, mk_result(8'h00, 0, 1'b1, hkct_pkg::ST_CHORD));
    add_row(8'h00, 8'h00, 8'h00, 1'b1, mk_result('0, 0, 1'b1, hkct_pkg::ST_REPEAT));
    add_row(8'h00, 8'h00, 8'h80, 1'b1, mk_result('0, 0, 1'b1, hkct_pkg::ST_EMPTY));
    // release of a key that is not held
    add_row(8'h55, 8'hAA, 8'h80, 1'b1, mk_result('0, 0, 1'b1, hkct_pkg::ST_EMPTY));
    add_row(8'hFF, 8'hFF, 8'h7F, 1'b1, mk_result(8'hFF, 0, 1'b1, hkct_pkg::ST_CHORD));
    add_row(8'hFF, 8'h01, 8'h00, 1'b1, mk_result('0, 0, 1'b1, hkct_pkg::ST_DUP));
    fill_keys = '{8'h80, 8'h10, 8'hF0, 8'h40, 8'h01, 8'hC0, 8'h20, 8'h90,
                  8'h08, 8'hE0, 8'h60, 8'h02, 8'hA0, 8'h30, 8'hFE};
    foreach (fill_keys[i])
      add_row(fill_keys[i], 8'h11 * i[7:0], 8'h01 << (i % 7), 1'b0, '0);
    add_row(8'h77, 8'h33, 8'h00, 1'b1, mk_result('0, 0, 1'b1, hkct_pkg::ST_FULL));
    // a refused press still becomes the last event
    add_row(8'h77, 8'h33, 8'h00, 1'b1, mk_result('0, 0, 1'b1, hkct_pkg::ST_REPEAT));
    add_row(8'hFF, 8'h00, 8'hFF, 1'b0, '0);
    add_row(8'h80, 8'h5A, 8'h80, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (key_rows[i]) issue(key_rows[i].ev, key_rows[i].typed, key_rows[i].want);
    last_sent = key_rows[key_rows.size() - 1].ev;
    drain_chords();

    press_pct = 50;
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 30 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 2);
        press_pct = (r == 0) ? 30 : (r == 1) ? 55 : 85;
      end
      if (n == RANDOM_EVENTS / 2) drain_chords();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        ev = last_sent;
      end else begin
        ev.scan_code   = 8'($urandom);
        ev.event_flags = 8'($urandom);
        ev.key_code    = 8'($urandom);
        if ($urandom_range(0, 99) < press_pct) begin
          ev.event_flags[7] = 1'b0;
          // press a held key now and then
          if (held_num > 0 && $urandom_range(0, 9) < 2)
            ev.key_code = held_set[$urandom_range(0, held_num - 1)];
        end else begin
          ev.event_flags[7] = 1'b1;
          if (held_num > 0 && $urandom_range(0, 9) < 7)
            ev.key_code = held_set[$urandom_range(0, held_num - 1)];
        end
      end
      issue(ev, 1'b0, '0);
      last_sent = ev;
    end

    start <= 1'b0;
    while (chord_expect.size() != 0) @(posedge clk);
    repeat (HELD_DEPTH + 4) @(posedge clk);
    if (chord_expect.size() != 0) errors++;

    $display("Sent %0d key events (%0d directed), checked %0d results:", events_sent,
             key_rows.size(), results_seen);
    $display("  %0d chord entries, %0d empty, %0d repeats, %0d duplicate presses, %0d full",
             status_seen[hkct_pkg::ST_CHORD], status_seen[hkct_pkg::ST_EMPTY],
             status_seen[hkct_pkg::ST_REPEAT], status_seen[hkct_pkg::ST_DUP],
             status_seen[hkct_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hkct_pkg.sv
rtl/hkct_cell.sv
rtl/held_key_chord_tracker_top.sv
test/tb_held_key_chord_tracker_top.sv
